// ===== rtl/core/iadm_pkg.sv =====
// shared types and constants of the iupac dna approximate matcher
package iadm_pkg;

  localparam int unsigned QueryBases = 32;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_QUERY_LOW     = 3'd0,
    REG_QUERY_HIGH    = 3'd1,
    REG_QUERY_LENGTH  = 3'd2,
    REG_MAX_MISMATCH  = 3'd3,
    REG_MAX_UNKNOWN   = 3'd4,
    REG_COMPLEMENT    = 3'd5,
    REG_REGION_ORIGIN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [4*QueryBases-1:0] query_codes;
    logic [5:0]              len;
    logic [5:0]              max_mm;
    logic [5:0]              max_uk;
    logic                    complement;
    logic [31:0]             origin;
  } cfg_t;

  typedef struct packed {
    logic [3:0] code;
    logic       unknown;
    logic       last;
  } base_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== rtl/core/iadm_front.sv =====
// front end: encodes target characters to iupac base masks
module iadm_front import iadm_pkg::*; (
  input  logic        in_valid_i,
  input  logic [7:0]  target_char_i,
  input  logic        last_base_i,
  input  logic        complement_i,
  input  logic        fifo_full_i,
  output logic        in_stall_o,
  output logic        push_o,
  output base_entry_t entry_o
);

  localparam logic [3:0] BaseA = 4'b0001;
  localparam logic [3:0] BaseT = 4'b0010;
  localparam logic [3:0] BaseG = 4'b0100;
  localparam logic [3:0] BaseC = 4'b1000;

  logic [7:0] uc;
  logic       is_dash;
  logic [3:0] code;

  always_comb begin
    uc      = {1'b0, target_char_i[6:0]};
    is_dash = (uc == "-");
    if (uc >= "a" && uc <= "z") begin
      uc = uc - 8'd32;
    end
    unique case (uc)
      "A":      code = BaseA;
      "C":      code = BaseC;
      "G":      code = BaseG;
      "T", "U": code = BaseT;
      "R":      code = BaseA | BaseG;
      "Y":      code = BaseT | BaseC;
      "M":      code = BaseA | BaseC;
      "K":      code = BaseG | BaseT;
      "S":      code = BaseC | BaseG;
      "W":      code = BaseA | BaseT;
      "H":      code = BaseA | BaseC | BaseT;
      "B":      code = BaseG | BaseC | BaseT;
      "V":      code = BaseG | BaseC | BaseA;
      "D":      code = BaseG | BaseA | BaseT;
      "N", "X": code = BaseA | BaseC | BaseG | BaseT;
      "-":      code = BaseA | BaseC | BaseG;
      default:  code = 4'b0000;
    endcase
    // swap a<->t and c<->g, dash keeps its mask
    if (complement_i && !is_dash) begin
      code = {code[2], code[3], code[0], code[1]};
    end
  end

  assign in_stall_o      = fifo_full_i;
  assign push_o          = in_valid_i && !fifo_full_i;
  assign entry_o.code    = code;
  assign entry_o.unknown = (target_char_i == "n") || (target_char_i == "x");
  assign entry_o.last    = last_base_i;

endmodule

// ===== rtl/core/iadm_fifo.sv =====
// short queue between front end and match engine
module iadm_fifo import iadm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  base_entry_t  entry_i,
  input  logic         pop_i,
  output base_entry_t  entry_o,
  output fifo_status_t status_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  base_entry_t     mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign entry_o        = mem_q[rd_q];
  assign status_o.full  = (cnt_q == CntW'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/core/iadm_back.sv =====
// match engine: window, mismatch and unknown counts, greedy match decision
module iadm_back import iadm_pkg::*; #(
  parameter int unsigned QUERY_MAX = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  fifo_status_t fifo_st_i,
  input  base_entry_t  entry_i,
  output logic         pop_o,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic [31:0]  match_start_o,
  output logic [31:0]  match_end_o
);

  localparam int unsigned WinDepth = (QUERY_MAX < QueryBases) ? QUERY_MAX : QueryBases;
  localparam int unsigned NumGrp   = (WinDepth + 7) / 8;
  localparam int unsigned PadW     = NumGrp * 8;
  localparam int unsigned CntW     = $clog2(WinDepth + 1);

  logic                adv;
  logic                pop;

  // window
  logic [3:0]          win_q   [WinDepth];
  logic [3:0]          win_nxt [WinDepth];
  logic [WinDepth-1:0] unk_q;
  logic [WinDepth-1:0] unk_nxt;
  logic [WinDepth-1:0] mm_vec;
  logic [WinDepth-1:0] uk_vec;
  logic [5:0]          qidx;
  logic [3:0]          qmask;
  logic [5:0]          lenm1;
  logic [31:0]         pos_q;

  // stage 1
  logic                s1_vld_q;
  logic [WinDepth-1:0] s1_mm_q;
  logic [WinDepth-1:0] s1_uk_q;
  logic [31:0]         s1_pos_q;
  logic [31:0]         s1_start_q;
  logic                s1_elig_q;
  logic                s1_last_q;

  // stage 2
  logic                s2_vld_q;
  logic [3:0]          s2_mm_grp_q [NumGrp];
  logic [3:0]          s2_uk_grp_q [NumGrp];
  logic [3:0]          mm_grp [NumGrp];
  logic [3:0]          uk_grp [NumGrp];
  logic [PadW-1:0]     mm_pad;
  logic [PadW-1:0]     uk_pad;
  logic [31:0]         s2_pos_q;
  logic [31:0]         s2_start_q;
  logic                s2_elig_q;
  logic                s2_last_q;
  logic [31:0]         s2_abs_start_q;
  logic [31:0]         s2_abs_end_q;

  // decision and output
  logic [CntW-1:0]     mm_sum;
  logic [CntW-1:0]     uk_sum;
  logic                hit;
  logic [31:0]         nas_q;
  logic                out_vld_q;
  logic [31:0]         out_start_q;
  logic [31:0]         out_end_q;

  assign adv   = !out_vld_q || !out_stall_i;
  assign pop   = adv && !fifo_st_i.empty;
  assign pop_o = pop;
  assign lenm1 = cfg_i.len - 6'd1;

  // shift in the new base and compare against the query reversed onto the window
  always_comb begin
    win_nxt[0] = entry_i.code;
    unk_nxt[0] = entry_i.unknown;
    for (int j = 1; j < WinDepth; j++) begin
      win_nxt[j] = win_q[j-1];
      unk_nxt[j] = unk_q[j-1];
    end
    qidx  = '0;
    qmask = '0;
    for (int j = 0; j < WinDepth; j++) begin
      qidx      = lenm1 - 6'(j);
      qmask     = cfg_i.query_codes[{qidx[4:0], 2'b00} +: 4];
      mm_vec[j] = (6'(j) < cfg_i.len) && ((qmask & win_nxt[j]) == 4'b0000);
      uk_vec[j] = (6'(j) < cfg_i.len) && unk_nxt[j];
    end
  end

  // group counts of eight bits each
  always_comb begin
    mm_pad = PadW'(s1_mm_q);
    uk_pad = PadW'(s1_uk_q);
    for (int g = 0; g < NumGrp; g++) begin
      mm_grp[g] = '0;
      uk_grp[g] = '0;
      for (int b = 0; b < 8; b++) begin
        mm_grp[g] = mm_grp[g] + 4'(mm_pad[g*8+b]);
        uk_grp[g] = uk_grp[g] + 4'(uk_pad[g*8+b]);
      end
    end
  end

  always_comb begin
    mm_sum = '0;
    uk_sum = '0;
    for (int g = 0; g < NumGrp; g++) begin
      mm_sum = mm_sum + CntW'(s2_mm_grp_q[g]);
      uk_sum = uk_sum + CntW'(s2_uk_grp_q[g]);
    end
    hit = s2_vld_q && s2_elig_q
          && (6'(mm_sum) <= cfg_i.max_mm)
          && (6'(uk_sum) <= cfg_i.max_uk)
          && (s2_start_q >= nas_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < WinDepth; j++) begin
        win_q[j] <= '0;
      end
      unk_q     <= '0;
      pos_q     <= '0;
      nas_q     <= '0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pop;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= hit;
      if (pop) begin
        // end of region clears the window and position
        for (int j = 0; j < WinDepth; j++) begin
          win_q[j] <= entry_i.last ? 4'b0000 : win_nxt[j];
        end
        unk_q <= entry_i.last ? '0 : unk_nxt;
        pos_q <= entry_i.last ? '0 : pos_q + 32'd1;
      end
      if (s2_vld_q) begin
        if (s2_last_q) begin
          nas_q <= '0;
        end else if (hit) begin
          nas_q <= s2_pos_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mm_q    <= mm_vec;
      s1_uk_q    <= uk_vec;
      s1_pos_q   <= pos_q;
      s1_start_q <= pos_q - 32'(lenm1);
      s1_elig_q  <= (pos_q >= 32'(lenm1));
      s1_last_q  <= entry_i.last;

      for (int g = 0; g < NumGrp; g++) begin
        s2_mm_grp_q[g] <= mm_grp[g];
        s2_uk_grp_q[g] <= uk_grp[g];
      end
      s2_pos_q       <= s1_pos_q;
      s2_start_q     <= s1_start_q;
      s2_elig_q      <= s1_elig_q;
      s2_last_q      <= s1_last_q;
      s2_abs_start_q <= cfg_i.origin + s1_start_q;
      s2_abs_end_q   <= cfg_i.origin + s1_pos_q;

      out_start_q <= s2_abs_start_q;
      out_end_q   <= s2_abs_end_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign match_start_o = out_start_q;
  assign match_end_o   = out_end_q;

endmodule

// ===== rtl/core/iupac_dna_approx_matcher.sv =====
// top level of the iupac dna approximate matcher
//
// Target characters arrive on the in channel (valid/stall), one per request,
// with last_base marking the final character of a search region. Each request
// that completes a matching window past the last reported match yields one
// match on the out channel, carrying start and end offset by region_origin.
// Registers are written through the cfg channel (valid/ready, index and data);
// ready is always high and writes are expected only while the block is idle.
// Throughput is one character per cycle while the output is not stalled. A
// character is written into a four-entry queue and then passes three registers
// in the match engine (window compare, group counts, count sum and greedy
// decision); a match appears on the out port from the last of these registers.
// When a match is stalled, the match engine and its output register hold;
// the queue keeps taking characters until it fills, then in_stall_o rises.
// Reset clears the registers to their defaults, empties the queue and clears
// the window, the position counter and the next allowed match start.
module iupac_dna_approx_matcher import iadm_pkg::*; #(
  parameter int unsigned QUERY_MAX = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          target_char_i,
  input  logic                last_base_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         match_start_o,
  output logic [31:0]         match_end_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned LenCap = (QUERY_MAX < QueryBases) ? QUERY_MAX : QueryBases;

  logic [63:0]  qlow_q;
  logic [63:0]  qhigh_q;
  logic [5:0]   qlen_q;
  logic [5:0]   max_mm_q;
  logic [5:0]   max_uk_q;
  logic         comp_q;
  logic [31:0]  origin_q;
  logic [5:0]   len_eff;
  cfg_t         cfg;

  logic         push;
  logic         pop;
  base_entry_t  front_entry;
  base_entry_t  fifo_entry;
  fifo_status_t fifo_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q   <= '0;
      qhigh_q  <= '0;
      qlen_q   <= 6'd1;
      max_mm_q <= '0;
      max_uk_q <= '0;
      comp_q   <= 1'b0;
      origin_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_QUERY_LOW:     qlow_q   <= cfg_data_i[63:0];
        REG_QUERY_HIGH:    qhigh_q  <= cfg_data_i[63:0];
        REG_QUERY_LENGTH:  qlen_q   <= cfg_data_i[5:0];
        REG_MAX_MISMATCH:  max_mm_q <= cfg_data_i[5:0];
        REG_MAX_UNKNOWN:   max_uk_q <= cfg_data_i[5:0];
        REG_COMPLEMENT:    comp_q   <= cfg_data_i[0];
        REG_REGION_ORIGIN: origin_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one, long lengths clamp to the window
  always_comb begin
    if (qlen_q == '0) begin
      len_eff = 6'd1;
    end else if (qlen_q > 6'(LenCap)) begin
      len_eff = 6'(LenCap);
    end else begin
      len_eff = qlen_q;
    end
  end

  assign cfg.query_codes = {qhigh_q, qlow_q};
  assign cfg.len         = len_eff;
  assign cfg.max_mm      = max_mm_q;
  assign cfg.max_uk      = max_uk_q;
  assign cfg.complement  = comp_q;
  assign cfg.origin      = origin_q;

  iadm_front u_front (
    .in_valid_i    (in_valid_i),
    .target_char_i (target_char_i),
    .last_base_i   (last_base_i),
    .complement_i  (cfg.complement),
    .fifo_full_i   (fifo_st.full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .entry_o       (front_entry)
  );

  iadm_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (front_entry),
    .pop_i    (pop),
    .entry_o  (fifo_entry),
    .status_o (fifo_st)
  );

  iadm_back #(
    .QUERY_MAX (QUERY_MAX)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .fifo_st_i     (fifo_st),
    .entry_i       (fifo_entry),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .match_start_o (match_start_o),
    .match_end_o   (match_end_o)
  );

`ifndef SYNTHESIS
  a_fifo_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.full && fifo_st.empty))
    else $error("queue reports full and empty together");

  a_fifo_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> !fifo_st.empty)
    else $error("queue empty after a push without a pop");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty)
    else $error("match engine popped an empty queue");

  a_match_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((match_end_o - match_start_o) == (32'(len_eff) - 32'd1)))
    else $error("match span differs from query length");
`endif

endmodule
